/* rtl/core/scc_pkg.sv */
// scc_pkg: shared constants, operation codes and controller/datapath structs
// for the strongly connected component labeler; no dependencies
`timescale 1ns / 1ps
package scc_pkg;

	localparam int MAX_NODES = 64;
	localparam int NODE_W    = 6;   // node index width
	localparam int CNT_W     = 7;   // count width, holds MAX_NODES itself
	localparam int STK_W     = NODE_W + CNT_W;

	localparam logic [1:0] KIND_EDGE  = 2'd0;
	localparam logic [1:0] KIND_RUN   = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [CNT_W-1:0] NODE_LIMIT = CNT_W'(MAX_NODES);

	typedef logic [4:0] op_t;

	localparam op_t OP_NONE       = 5'd0;
	localparam op_t OP_EDGE_RD    = 5'd1;
	localparam op_t OP_EDGE_WR    = 5'd2;
	localparam op_t OP_CLEAR      = 5'd3;
	localparam op_t OP_F_INIT     = 5'd4;
	localparam op_t OP_F_SKIP     = 5'd5;
	localparam op_t OP_F_VISIT    = 5'd6;
	localparam op_t OP_LOAD_FWD   = 5'd7;
	localparam op_t OP_F_FINISH   = 5'd8;
	localparam op_t OP_F_PUSH     = 5'd9;
	localparam op_t OP_STEP       = 5'd10;
	localparam op_t OP_F_POP      = 5'd11;
	localparam op_t OP_B_INIT     = 5'd12;
	localparam op_t OP_B_FO_RD    = 5'd13;
	localparam op_t OP_B_SKIP     = 5'd14;
	localparam op_t OP_B_ROOT     = 5'd15;
	localparam op_t OP_LOAD_BWD   = 5'd16;
	localparam op_t OP_B_PUSH     = 5'd17;
	localparam op_t OP_B_END      = 5'd18;
	localparam op_t OP_B_POP      = 5'd19;
	localparam op_t OP_E_INIT     = 5'd20;
	localparam op_t OP_E_RD       = 5'd21;
	localparam op_t OP_E_NEXT     = 5'd22;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic root_end;
		logic root_visited;
		logic scan_end;
		logic hit_fwd;
		logic hit_bwd;
		logic sp_zero;
		logic idx_end;
		logic fo_assigned;
		logic emit_last;
	} status_t;

endpackage

/* rtl/core/scc_labeler_core.sv */
// an add-edge item reads both memory rows, then writes them back; a clear acts
// at acceptance and kind 3 does nothing; a run does the forward search, the backward
// search, then emission; the row scans over the adjacency memories test one bit per cycle
// one item at a time; in_stall is high through an edge write and until a run's last result
// arst_n clears the graph (row valid bits), the sequencer and node_count to 64
// top level of the strongly connected component labeler; depends on scc_pkg,
// scc_ctrl and scc_dp
`timescale 1ns / 1ps
module scc_labeler_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration: node count in use
	input  logic                        cfg_we,
	input  logic [scc_pkg::CNT_W-1:0]   cfg_wdata,
	// item channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  kind,
	input  logic [scc_pkg::NODE_W-1:0]  src_node,
	input  logic [scc_pkg::NODE_W-1:0]  dst_node,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [scc_pkg::NODE_W-1:0]  node_index,
	output logic [scc_pkg::CNT_W-1:0]   component_id,
	output logic                        last
);

	logic [scc_pkg::CNT_W-1:0] node_count_q;
	logic [scc_pkg::CNT_W-1:0] n_eff;
	scc_pkg::cmd_t             cmd;
	scc_pkg::status_t          st;

	// register keeps the written bits; the clamp applies on use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= scc_pkg::NODE_LIMIT;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// zero counts as one node, anything above the limit as the limit
	always_comb begin
		priority if (node_count_q == '0) begin
			n_eff = scc_pkg::CNT_W'(1);
		end else if (node_count_q > scc_pkg::NODE_LIMIT) begin
			n_eff = scc_pkg::NODE_LIMIT;
		end else begin
			n_eff = node_count_q;
		end
	end

	// sequencer: decodes the item kind, walks both search passes and the emission
	scc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.out_stall (out_stall),
		.st        (st),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// graph storage, stack, finish order, labels and counters
	scc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.n_eff        (n_eff),
		.src_node     (src_node),
		.dst_node     (dst_node),
		.st           (st),
		.node_index   (node_index),
		.component_id (component_id),
		.last         (last)
	);

`ifndef NO_ASSERTIONS
	// no item is taken while a result is on offer
	a_stall_on_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("item channel open during result");

	// every reported node carries an assigned label
	a_label_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> component_id != '0) else $error("unassigned label emitted");

	// the final transfer of a run ends the result stream
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid && !in_stall)
		else $error("results continue after last");

	// a run item closes the item channel on the next cycle
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind == scc_pkg::KIND_RUN |=> in_stall)
		else $error("run did not start");
`endif

endmodule

/* rtl/core/scc_ctrl.sv */
// scc_ctrl: sequencer for edge loads, clears, the two search passes and emission
// depends on scc_pkg
`timescale 1ns / 1ps
module scc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        kind,
	input  logic              out_stall,
	input  scc_pkg::status_t  st,
	output logic              in_stall,
	output logic              out_valid,
	output scc_pkg::cmd_t     cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_A_WR   = 4'd1;
	localparam logic [3:0] S_F_ROOT = 4'd2;
	localparam logic [3:0] S_F_LOAD = 4'd3;
	localparam logic [3:0] S_F_SCAN = 4'd4;
	localparam logic [3:0] S_F_POP  = 4'd5;
	localparam logic [3:0] S_B_IDX  = 4'd6;
	localparam logic [3:0] S_B_FO   = 4'd7;
	localparam logic [3:0] S_B_LOAD = 4'd8;
	localparam logic [3:0] S_B_SCAN = 4'd9;
	localparam logic [3:0] S_B_POP  = 4'd10;
	localparam logic [3:0] S_E_RD   = 4'd11;
	localparam logic [3:0] S_E_OUT  = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_E_OUT);

	always_comb begin
		state_d = state_q;
		cmd.op  = scc_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (kind)
						scc_pkg::KIND_EDGE: begin
							cmd.op  = scc_pkg::OP_EDGE_RD;
							state_d = S_A_WR;
						end
						scc_pkg::KIND_RUN: begin
							cmd.op  = scc_pkg::OP_F_INIT;
							state_d = S_F_ROOT;
						end
						scc_pkg::KIND_CLEAR: begin
							cmd.op = scc_pkg::OP_CLEAR;
						end
						default: begin
							cmd.op = scc_pkg::OP_NONE;
						end
					endcase
				end
			end
			S_A_WR: begin
				cmd.op  = scc_pkg::OP_EDGE_WR;
				state_d = S_IDLE;
			end
			S_F_ROOT: begin
				if (st.root_end) begin
					cmd.op  = scc_pkg::OP_B_INIT;
					state_d = S_B_IDX;
				end else if (st.root_visited) begin
					cmd.op = scc_pkg::OP_F_SKIP;
				end else begin
					cmd.op  = scc_pkg::OP_F_VISIT;
					state_d = S_F_LOAD;
				end
			end
			S_F_LOAD: begin
				cmd.op  = scc_pkg::OP_LOAD_FWD;
				state_d = S_F_SCAN;
			end
			S_F_SCAN: begin
				if (st.scan_end) begin
					cmd.op  = scc_pkg::OP_F_FINISH;
					state_d = st.sp_zero ? S_F_ROOT : S_F_POP;
				end else if (st.hit_fwd) begin
					cmd.op  = scc_pkg::OP_F_PUSH;
					state_d = S_F_LOAD;
				end else begin
					cmd.op = scc_pkg::OP_STEP;
				end
			end
			S_F_POP: begin
				cmd.op  = scc_pkg::OP_F_POP;
				state_d = S_F_LOAD;
			end
			S_B_IDX: begin
				if (st.idx_end) begin
					cmd.op  = scc_pkg::OP_E_INIT;
					state_d = S_E_RD;
				end else begin
					cmd.op  = scc_pkg::OP_B_FO_RD;
					state_d = S_B_FO;
				end
			end
			S_B_FO: begin
				if (st.fo_assigned) begin
					cmd.op  = scc_pkg::OP_B_SKIP;
					state_d = S_B_IDX;
				end else begin
					cmd.op  = scc_pkg::OP_B_ROOT;
					state_d = S_B_LOAD;
				end
			end
			S_B_LOAD: begin
				cmd.op  = scc_pkg::OP_LOAD_BWD;
				state_d = S_B_SCAN;
			end
			S_B_SCAN: begin
				if (st.scan_end) begin
					cmd.op  = scc_pkg::OP_B_END;
					state_d = st.sp_zero ? S_B_IDX : S_B_POP;
				end else if (st.hit_bwd) begin
					cmd.op = scc_pkg::OP_B_PUSH;
				end else begin
					cmd.op = scc_pkg::OP_STEP;
				end
			end
			S_B_POP: begin
				cmd.op  = scc_pkg::OP_B_POP;
				state_d = S_B_LOAD;
			end
			S_E_RD: begin
				cmd.op  = scc_pkg::OP_E_RD;
				state_d = S_E_OUT;
			end
			S_E_OUT: begin
				if (!out_stall) begin
					cmd.op  = scc_pkg::OP_E_NEXT;
					state_d = st.emit_last ? S_IDLE : S_E_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/scc_dp.sv */
// scc_dp: adjacency and transpose memories, search stack, finish order, labels
// and the counters of both passes; depends on scc_pkg
`timescale 1ns / 1ps
module scc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scc_pkg::cmd_t                 cmd,
	input  logic [scc_pkg::CNT_W-1:0]     n_eff,
	input  logic [scc_pkg::NODE_W-1:0]    src_node,
	input  logic [scc_pkg::NODE_W-1:0]    dst_node,
	output scc_pkg::status_t              st,
	output logic [scc_pkg::NODE_W-1:0]    node_index,
	output logic [scc_pkg::CNT_W-1:0]     component_id,
	output logic                          last
);

	localparam int N  = scc_pkg::MAX_NODES;
	localparam int NW = scc_pkg::NODE_W;
	localparam int CW = scc_pkg::CNT_W;

	logic [N-1:0]  adj_mem  [N];
	logic [N-1:0]  adjt_mem [N];
	logic [scc_pkg::STK_W-1:0] stk_mem [N];
	logic [NW-1:0] fo_mem   [N];
	logic [CW-1:0] lbl_mem  [N];

	logic [N-1:0]  adj_vld_q, adjt_vld_q, visited_q, assigned_q;
	logic [N-1:0]  adj_rd_q, adjt_rd_q, row_q;
	logic          adj_rvld_q, adjt_rvld_q;
	logic [scc_pkg::STK_W-1:0] stk_rd_q;
	logic [NW-1:0] fo_rd_q;
	logic [CW-1:0] lbl_rd_q;
	logic [CW-1:0] root_q, cur_w_q, sp_q, pos_q, idx_q, label_q, e_q;
	logic [NW-1:0] cur_v_q, edge_src_q, edge_dst_q;
	logic          edge_ok_q;

	logic [NW-1:0] adj_raddr, adjt_raddr;
	logic [NW-1:0] stk_node;
	logic [CW-1:0] stk_scan;
	logic [CW-1:0] sp_dec, pos_dec;

	assign stk_node = stk_rd_q[scc_pkg::STK_W-1:CW];
	assign stk_scan = stk_rd_q[CW-1:0];
	assign sp_dec   = sp_q - CW'(1);
	assign pos_dec  = pos_q - CW'(1);

	always_comb begin
		adj_raddr = root_q[NW-1:0];
		unique case (cmd.op)
			scc_pkg::OP_EDGE_RD: adj_raddr = src_node;
			scc_pkg::OP_F_PUSH:  adj_raddr = cur_w_q[NW-1:0];
			scc_pkg::OP_F_POP:   adj_raddr = stk_node;
			default:             adj_raddr = root_q[NW-1:0];
		endcase
	end

	always_comb begin
		adjt_raddr = stk_node;
		unique case (cmd.op)
			scc_pkg::OP_EDGE_RD: adjt_raddr = dst_node;
			scc_pkg::OP_B_ROOT:  adjt_raddr = fo_rd_q;
			default:             adjt_raddr = stk_node;
		endcase
	end

	assign st.root_end     = (root_q == n_eff);
	assign st.root_visited = visited_q[root_q[NW-1:0]];
	assign st.scan_end     = (cur_w_q == n_eff);
	assign st.hit_fwd      = row_q[cur_w_q[NW-1:0]] && !visited_q[cur_w_q[NW-1:0]];
	assign st.hit_bwd      = row_q[cur_w_q[NW-1:0]] && !assigned_q[cur_w_q[NW-1:0]];
	assign st.sp_zero      = (sp_q == '0);
	assign st.idx_end      = (idx_q == n_eff);
	assign st.fo_assigned  = assigned_q[fo_rd_q];
	assign st.emit_last    = ((e_q + CW'(1)) == n_eff);

	assign node_index   = e_q[NW-1:0];
	assign component_id = lbl_rd_q;
	assign last         = st.emit_last;

	// memories, registered reads
	always_ff @(posedge clk) begin
		adj_rd_q    <= adj_mem[adj_raddr];
		adj_rvld_q  <= adj_vld_q[adj_raddr];
		adjt_rd_q   <= adjt_mem[adjt_raddr];
		adjt_rvld_q <= adjt_vld_q[adjt_raddr];
		stk_rd_q    <= stk_mem[sp_dec[NW-1:0]];
		fo_rd_q     <= fo_mem[idx_q[NW-1:0]];
		lbl_rd_q    <= lbl_mem[e_q[NW-1:0]];
		if (cmd.op == scc_pkg::OP_EDGE_WR && edge_ok_q) begin
			adj_mem[edge_src_q]  <= (adj_rvld_q ? adj_rd_q : '0)
				| (N'(1) << edge_dst_q);
			adjt_mem[edge_dst_q] <= (adjt_rvld_q ? adjt_rd_q : '0)
				| (N'(1) << edge_src_q);
		end
		if (cmd.op == scc_pkg::OP_F_PUSH) begin
			stk_mem[sp_q[NW-1:0]] <= {cur_v_q, cur_w_q + CW'(1)};
		end
		if (cmd.op == scc_pkg::OP_B_PUSH) begin
			stk_mem[sp_q[NW-1:0]] <= {cur_w_q[NW-1:0], CW'(0)};
		end
		if (cmd.op == scc_pkg::OP_F_FINISH) begin
			fo_mem[pos_dec[NW-1:0]] <= cur_v_q;
		end
		if (cmd.op == scc_pkg::OP_B_ROOT) begin
			lbl_mem[fo_rd_q] <= label_q + CW'(1);
		end
		if (cmd.op == scc_pkg::OP_B_PUSH) begin
			lbl_mem[cur_w_q[NW-1:0]] <= label_q;
		end
		if (cmd.op == scc_pkg::OP_EDGE_RD) begin
			edge_src_q <= src_node;
			edge_dst_q <= dst_node;
			edge_ok_q  <= ({1'b0, src_node} < scc_pkg::NODE_LIMIT)
				&& ({1'b0, dst_node} < scc_pkg::NODE_LIMIT);
		end
		if (cmd.op == scc_pkg::OP_LOAD_FWD) begin
			row_q <= adj_rvld_q ? adj_rd_q : '0;
		end
		if (cmd.op == scc_pkg::OP_LOAD_BWD) begin
			row_q <= adjt_rvld_q ? adjt_rd_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_vld_q  <= '0;
			adjt_vld_q <= '0;
			visited_q  <= '0;
			assigned_q <= '0;
			root_q     <= '0;
			cur_v_q    <= '0;
			cur_w_q    <= '0;
			sp_q       <= '0;
			pos_q      <= '0;
			idx_q      <= '0;
			label_q    <= '0;
			e_q        <= '0;
		end else begin
			unique case (cmd.op)
				scc_pkg::OP_EDGE_WR: begin
					if (edge_ok_q) begin
						adj_vld_q[edge_src_q]  <= 1'b1;
						adjt_vld_q[edge_dst_q] <= 1'b1;
					end
				end
				scc_pkg::OP_CLEAR: begin
					adj_vld_q  <= '0;
					adjt_vld_q <= '0;
				end
				scc_pkg::OP_F_INIT: begin
					visited_q <= '0;
					root_q    <= '0;
					pos_q     <= n_eff;
					sp_q      <= '0;
				end
				scc_pkg::OP_F_SKIP: begin
					root_q <= root_q + CW'(1);
				end
				scc_pkg::OP_F_VISIT: begin
					visited_q[root_q[NW-1:0]] <= 1'b1;
					cur_v_q <= root_q[NW-1:0];
					cur_w_q <= '0;
					root_q  <= root_q + CW'(1);
				end
				scc_pkg::OP_F_FINISH: begin
					pos_q <= pos_dec;
					if (sp_q != '0) begin
						sp_q <= sp_dec;
					end
				end
				scc_pkg::OP_F_PUSH: begin
					visited_q[cur_w_q[NW-1:0]] <= 1'b1;
					sp_q    <= sp_q + CW'(1);
					cur_v_q <= cur_w_q[NW-1:0];
					cur_w_q <= '0;
				end
				scc_pkg::OP_STEP: begin
					cur_w_q <= cur_w_q + CW'(1);
				end
				scc_pkg::OP_F_POP: begin
					cur_v_q <= stk_node;
					cur_w_q <= stk_scan;
				end
				scc_pkg::OP_B_INIT: begin
					assigned_q <= '0;
					label_q    <= '0;
					idx_q      <= '0;
					sp_q       <= '0;
				end
				scc_pkg::OP_B_SKIP: begin
					idx_q <= idx_q + CW'(1);
				end
				scc_pkg::OP_B_ROOT: begin
					assigned_q[fo_rd_q] <= 1'b1;
					label_q <= label_q + CW'(1);
					cur_v_q <= fo_rd_q;
					cur_w_q <= '0;
					idx_q   <= idx_q + CW'(1);
				end
				scc_pkg::OP_B_PUSH: begin
					assigned_q[cur_w_q[NW-1:0]] <= 1'b1;
					sp_q    <= sp_q + CW'(1);
					cur_w_q <= cur_w_q + CW'(1);
				end
				scc_pkg::OP_B_END: begin
					if (sp_q != '0) begin
						sp_q <= sp_dec;
					end
				end
				scc_pkg::OP_B_POP: begin
					cur_v_q <= stk_node;
					cur_w_q <= '0;
				end
				scc_pkg::OP_E_INIT: begin
					e_q <= '0;
				end
				scc_pkg::OP_E_NEXT: begin
					e_q <= e_q + CW'(1);
				end
				default: begin
					e_q <= e_q;
				end
			endcase
		end
	end

endmodule

/* tb/tb_scc_labeler_core.sv */
// self-checking testbench for scc_labeler_core: drives edge, clear, run and no-op
// transfers, predicts component labels with a local kosaraju model; uses scc_pkg
`timescale 1ns / 1ps
module tb_scc_labeler_core;

	localparam logic [1:0] KIND_NOP = 2'd3;

	// clock and reset
	logic clk;
	logic arst_n;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// block ports
	logic                       cfg_we;
	logic [scc_pkg::CNT_W-1:0]  cfg_wdata;
	logic                       in_valid;
	logic                       in_stall;
	logic [1:0]                 kind;
	logic [scc_pkg::NODE_W-1:0] src_node;
	logic [scc_pkg::NODE_W-1:0] dst_node;
	logic                       out_valid;
	logic                       out_stall;
	logic [scc_pkg::NODE_W-1:0] node_index;
	logic [scc_pkg::CNT_W-1:0]  component_id;
	logic                       last;

	scc_labeler_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.src_node     (src_node),
		.dst_node     (dst_node),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.node_index   (node_index),
		.component_id (component_id),
		.last         (last)
	);

	// one expected label transfer
	typedef struct packed {
		logic [scc_pkg::NODE_W-1:0] node;
		logic [scc_pkg::CNT_W-1:0]  comp;
		logic                       fin;
	} label_t;

	label_t pending_labels[$];

	// shadow of the graph and the node count register
	logic [scc_pkg::MAX_NODES-1:0] graph[scc_pkg::MAX_NODES];
	logic [scc_pkg::CNT_W-1:0]     count_reg;

	int mismatches;
	int idle_cycles;
	bit timed_out;

	// clamp the register value the way the block uses it
	function automatic int used_nodes();
		int n;
		n = count_reg;
		if (n == 0) n = 1;
		if (n > scc_pkg::MAX_NODES) n = scc_pkg::MAX_NODES;
		return n;
	endfunction

	// kosaraju on the shadow graph, pushes n expected labels
	task automatic predict_labels();
		int n, pos, sp, v, w, u, p, i, cur;
		bit pushed;
		logic [scc_pkg::MAX_NODES-1:0] seen;
		int order[scc_pkg::MAX_NODES];
		int stack[scc_pkg::MAX_NODES];
		int scan[scc_pkg::MAX_NODES];
		int comp[scc_pkg::MAX_NODES];
		n = used_nodes();
		pos = n;
		seen = '0;
		// forward search, post-order written from the top down
		for (int r = 0; r < n; r++) begin
			if (seen[r]) continue;
			seen[r] = 1'b1;
			scan[r] = 0;
			stack[0] = r;
			sp = 1;
			while (sp > 0) begin
				v = stack[sp-1];
				pushed = 0;
				while (scan[v] < n) begin
					w = scan[v];
					scan[v] = w + 1;
					if (graph[v][w] && !seen[w]) begin
						seen[w] = 1'b1;
						scan[w] = 0;
						stack[sp] = w;
						sp++;
						pushed = 1;
						break;
					end
				end
				if (!pushed) begin
					sp--;
					pos--;
					order[pos] = v;
				end
			end
		end
		// backward search over predecessors
		for (i = 0; i < n; i++) comp[i] = 0;
		cur = 0;
		for (i = 0; i < n; i++) begin
			v = order[i];
			if (comp[v] != 0) continue;
			cur++;
			comp[v] = cur;
			stack[0] = v;
			sp = 1;
			while (sp > 0) begin
				sp--;
				u = stack[sp];
				for (p = 0; p < n; p++) begin
					if (comp[p] == 0 && graph[p][u]) begin
						comp[p] = cur;
						stack[sp] = p;
						sp++;
					end
				end
			end
		end
		for (i = 0; i < n; i++)
			pending_labels.push_back('{scc_pkg::NODE_W'(i),
				scc_pkg::CNT_W'(comp[i]), i == n - 1});
	endtask

	// send one item, updating the shadow at acceptance
	// valid stays up into the next item when no gap is drawn
	task automatic send_item(input logic [1:0] k, input int s, input int d);
		int gap;
		gap = $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		src_node <= scc_pkg::NODE_W'(s);
		dst_node <= scc_pkg::NODE_W'(d);
		do @(posedge clk); while (in_stall);
		case (k)
			scc_pkg::KIND_EDGE:  graph[s][d] = 1'b1;
			scc_pkg::KIND_CLEAR:
				for (int i = 0; i < scc_pkg::MAX_NODES; i++) graph[i] = '0;
			scc_pkg::KIND_RUN:   predict_labels();
			default: ;
		endcase
	endtask

	// drop valid, wait for all labels, then the tail latency of the last item
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_labels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// write node_count while idle
	task automatic set_node_count(input int value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= scc_pkg::CNT_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		count_reg = scc_pkg::CNT_W'(value);
	endtask

	// result checker with random stall
	always @(posedge clk) begin
		label_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_labels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected label transfer node %0d comp %0d", node_index,
						component_id);
			end else begin
				want = pending_labels.pop_front();
				if (node_index !== want.node || component_id !== want.comp ||
					last !== want.fin) begin
					mismatches++;
					if (mismatches <= 10)
						$display("label mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
							want.node, want.comp, want.fin, node_index, component_id, last);
				end
			end
		end
	end

	// receiver draws a stall length per transfer, sometimes none at all
	int stall_left;
	bit stall_free;
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (out_valid && !out_stall && !stall_free)
				stall_left <= $urandom_range(0, 16);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 200000 && !timed_out) begin
			timed_out = 1;
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic test_directed();
		set_node_count(4);
		send_item(scc_pkg::KIND_RUN, 0, 0);    // no edges, every node alone
		send_item(scc_pkg::KIND_EDGE, 0, 1);
		send_item(scc_pkg::KIND_EDGE, 1, 2);
		send_item(scc_pkg::KIND_EDGE, 2, 0);
		send_item(scc_pkg::KIND_EDGE, 2, 2);   // self loop
		send_item(scc_pkg::KIND_EDGE, 0, 1);   // duplicate
		send_item(scc_pkg::KIND_EDGE, 3, 63);  // edge to an unused node
		send_item(scc_pkg::KIND_EDGE, 63, 3);
		send_item(KIND_NOP, 5, 6);
		send_item(scc_pkg::KIND_RUN, 0, 0);
		set_node_count(0);                     // used as one node
		send_item(scc_pkg::KIND_RUN, 63, 63);
		set_node_count(127);                   // above the limit
		send_item(scc_pkg::KIND_RUN, 0, 0);
		set_node_count(64);
		send_item(scc_pkg::KIND_EDGE, 63, 0);
		send_item(scc_pkg::KIND_EDGE, 0, 63);
		send_item(scc_pkg::KIND_RUN, 0, 0);
		send_item(scc_pkg::KIND_CLEAR, 0, 0);
		set_node_count(1);
		send_item(scc_pkg::KIND_RUN, 0, 0);
	endtask

	task automatic test_random_graphs();
		int n, r, s, d;
		for (int g = 0; g < 12; g++) begin
			n = (g % 5 == 4) ? 64 : $urandom_range(2, 12);
			stall_free = (g % 4 == 1);
			set_node_count(n);
			send_item(scc_pkg::KIND_CLEAR, $urandom, $urandom);
			r = $urandom_range(3, 14);
			for (int e = 0; e < r; e++) begin
				s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
				d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
				if ($urandom_range(0, 19) == 0) send_item(KIND_NOP, s, d);
				else send_item(scc_pkg::KIND_EDGE, s, d);
			end
			send_item(scc_pkg::KIND_RUN, $urandom, $urandom);
			if (g == 6) drain();                  // sender waits for all labels
		end
		stall_free = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		clk = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		kind = scc_pkg::KIND_EDGE;
		src_node = '0;
		dst_node = '0;
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 0;
		stall_left = 0;
		stall_free = 0;
		count_reg = scc_pkg::CNT_W'(scc_pkg::MAX_NODES);
		for (int i = 0; i < scc_pkg::MAX_NODES; i++) graph[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_graphs();
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_labels.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
